// File: sv/double_ended_queue_macros.svh
// Assertion macros shared by the double-ended queue checker.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Checked on every rising edge outside of reset.
`define DQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define DQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/dq_pkg.sv
// Shared constants, types and ring helpers for the double-ended queue.
package dq_pkg;

  localparam int DEPTH  = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int REQ_W  = 3;
  localparam int STAT_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_PEEK_FRONT = 3'd4,
    REQ_PEEK_BACK  = 3'd5,
    REQ_DUMP       = 3'd6
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_STREAM
  } fsm_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [WORD_W-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } ram_rd_t;

  // Ring position of idx advanced by off, where off stays below DEPTH.
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - IDX_W){1'b0}}, idx} + {1'b0, off};
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] idx);
    return (idx == '0) ? IDX_W'(DEPTH - 1) : idx - 1'b1;
  endfunction

endpackage

// File: sv/double_ended_queue.sv
// Push and full/empty results are registered and appear in the cycle after the input beat;
// pop and peek results pass the store's registered read port, then the output register.
// Unless the output stalls, pushes and rejected requests are taken one per cycle and
// a dump streams one beat per cycle from the store; a pop, peek or dump blocks input until
// its last beat is registered. Reset clears the front index, the entry count and the
// output beat; the store itself is not cleared, and only pushed entries are ever read.
module double_ended_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [dq_pkg::WORD_W-1:0]   s_tdata,   // [31:0] push_value
  input  logic [dq_pkg::REQ_W-1:0]    s_tuser,   // [2:0] req_type
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [dq_pkg::WORD_W-1:0]   m_tdata,   // [31:0] item_value
  output logic [dq_pkg::STAT_W-1:0]   m_tuser,   // [1:0] status
  output logic                        m_tlast
);
  import dq_pkg::*;

  fsm_t              state, state_next;
  logic [IDX_W-1:0]  front, front_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  cnt_left, cnt_left_next;
  logic [IDX_W-1:0]  rd_pos, rd_pos_next;
  logic              m_tvalid_next;
  logic [WORD_W-1:0] m_tdata_next;
  logic [STAT_W-1:0] m_tuser_next;
  logic              m_tlast_next;

  ram_wr_t           wr;
  ram_rd_t           rd;
  logic [WORD_W-1:0] rd_data;

  req_t req;
  logic in_beat, out_free, is_empty, is_full, launch;

  assign req      = req_t'(s_tuser);
  assign out_free = !m_tvalid || m_tready;
  assign in_beat  = s_tvalid && s_tready;
  assign is_empty = (count == '0);
  assign is_full  = (count == CNT_W'(DEPTH));
  assign launch   = in_beat && !is_empty &&
                    (req == REQ_POP_FRONT || req == REQ_POP_BACK ||
                     req == REQ_PEEK_FRONT || req == REQ_PEEK_BACK || req == REQ_DUMP);

  dq_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (launch) begin
          state_next = S_STREAM;
        end
      end
      S_STREAM: begin
        if (out_free && cnt_left == CNT_W'(1)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // No write happens while a read is outstanding, so the store needs no forwarding.
  always_comb begin
    s_tready      = 1'b0;
    wr            = '0;
    rd.en         = 1'b0;
    rd.addr       = front;
    front_next    = front;
    count_next    = count;
    cnt_left_next = cnt_left;
    rd_pos_next   = rd_pos;
    m_tvalid_next = m_tvalid && !m_tready;
    m_tdata_next  = m_tdata;
    m_tuser_next  = m_tuser;
    m_tlast_next  = m_tlast;
    unique case (state)
      S_IDLE: begin
        s_tready = out_free;
        if (in_beat) begin
          m_tdata_next = '0;
          m_tuser_next = STAT_OK;
          m_tlast_next = 1'b1;
          unique case (req)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
              m_tvalid_next = 1'b1;
              if (is_full) begin
                m_tuser_next = STAT_FULL;
              end else begin
                wr.en      = 1'b1;
                wr.data    = s_tdata;
                count_next = count + 1'b1;
                if (req == REQ_PUSH_FRONT) begin
                  front_next = ring_dec(front);
                  wr.addr    = ring_dec(front);
                end else begin
                  wr.addr = ring_add(front, count);
                end
              end
            end
            REQ_POP_FRONT, REQ_POP_BACK, REQ_PEEK_FRONT, REQ_PEEK_BACK: begin
              if (is_empty) begin
                m_tvalid_next = 1'b1;
                m_tuser_next  = STAT_EMPTY;
              end else begin
                rd.en         = 1'b1;
                cnt_left_next = CNT_W'(1);
                if (req == REQ_POP_BACK || req == REQ_PEEK_BACK) begin
                  rd.addr = ring_add(front, count - 1'b1);
                end
                if (req == REQ_POP_FRONT) begin
                  front_next = ring_inc(front);
                end
                if (req == REQ_POP_FRONT || req == REQ_POP_BACK) begin
                  count_next = count - 1'b1;
                end
              end
            end
            REQ_DUMP: begin
              if (is_empty) begin
                m_tvalid_next = 1'b1;
                m_tuser_next  = STAT_EMPTY;
              end else begin
                rd.en         = 1'b1;
                rd_pos_next   = ring_inc(front);
                cnt_left_next = count;
              end
            end
            default: m_tvalid_next = 1'b1;
          endcase
        end
      end
      S_STREAM: begin
        if (out_free) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = rd_data;
          m_tuser_next  = STAT_OK;
          m_tlast_next  = (cnt_left == CNT_W'(1));
          cnt_left_next = cnt_left - 1'b1;
          if (cnt_left != CNT_W'(1)) begin
            rd.en       = 1'b1;
            rd.addr     = rd_pos;
            rd_pos_next = ring_inc(rd_pos);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      front    <= '0;
      count    <= '0;
      cnt_left <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      front    <= front_next;
      count    <= count_next;
      cnt_left <= cnt_left_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_pos  <= rd_pos_next;
    m_tdata <= m_tdata_next;
    m_tuser <= m_tuser_next;
    m_tlast <= m_tlast_next;
  end

endmodule

// File: sv/dq_ram.sv
// Entry store: one write port and one registered read port.
module dq_ram (
  input  logic                        clk,
  input  dq_pkg::ram_wr_t             wr,
  input  dq_pkg::ram_rd_t             rd,
  output logic [dq_pkg::WORD_W-1:0]   rd_data
);
  import dq_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

// File: sv/dq_checker.sv
// Port-level checks for the double-ended queue, bound to the top level.
module dq_port_checks (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [dq_pkg::WORD_W-1:0]   m_tdata,
  input logic [dq_pkg::STAT_W-1:0]   m_tuser,
  input logic                        m_tlast
);
  import dq_pkg::*;
`include "double_ended_queue_macros.svh"

  `DQ_ASSERT_ALWAYS(a_reset_clears_out, rst |=> !m_tvalid, "output beat valid after reset")
  `DQ_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled output beat changed")
  `DQ_ASSERT(a_reject_single, m_tvalid && m_tuser != STAT_OK |-> m_tdata == '0 && m_tlast, "empty or full beat must be a zero final beat")
  `DQ_ASSERT(a_dump_blocks_input, m_tvalid && !m_tlast |-> !s_tready, "input taken while a dump is unfinished")
  `DQ_ASSERT(a_status_code, m_tvalid |-> m_tuser != 2'd3, "undefined status code on output")

endmodule

bind double_ended_queue dq_port_checks u_dq_port_checks (.*);

// File: dv/dq_checker.sv
`timescale 1ns / 1ps
// Result checker for the double-ended queue: mirrors the ring store and compares every beat.
module dq_checker
  import dq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [WORD_W-1:0] s_tdata,   // [31:0] push_value
  input  logic [REQ_W-1:0]  s_tuser,   // [2:0] req_type
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [WORD_W-1:0] m_tdata,   // [31:0] item_value
  input  logic [STAT_W-1:0] m_tuser,   // [1:0] status
  input  logic              m_tlast,
  output int                fail_count,
  output int                pending,
  output int                beat_count,
  output int                full_count,
  output int                empty_count
);

  typedef struct {
    logic [WORD_W-1:0] value;
    status_t           status;
    logic              last;
  } dq_beat_t;

  dq_beat_t          expected_beats[$];
  logic [WORD_W-1:0] ring_words[DEPTH];
  int                head_slot;
  int                fill_level;

  function automatic void expect_beat(input logic [WORD_W-1:0] value, input status_t status,
                                      input logic last);
    dq_beat_t b;
    b.value  = value;
    b.status = status;
    b.last   = last;
    expected_beats.push_back(b);
  endfunction

  // Applies one accepted request to the mirrored ring and queues the beats it must produce.
  function automatic void predict_request(input logic [REQ_W-1:0] code,
                                          input logic [WORD_W-1:0] word);
    int slot;
    case (code)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (fill_level == DEPTH) begin
          expect_beat('0, STAT_FULL, 1'b1);
        end else begin
          if (code == REQ_PUSH_FRONT) begin
            head_slot = (head_slot + DEPTH - 1) % DEPTH;
            slot = head_slot;
          end else begin
            slot = (head_slot + fill_level) % DEPTH;
          end
          ring_words[slot] = word;
          fill_level++;
          expect_beat('0, STAT_OK, 1'b1);
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK, REQ_PEEK_FRONT, REQ_PEEK_BACK: begin
        if (fill_level == 0) begin
          expect_beat('0, STAT_EMPTY, 1'b1);
        end else begin
          slot = (code == REQ_POP_FRONT || code == REQ_PEEK_FRONT) ?
                 head_slot : (head_slot + fill_level - 1) % DEPTH;
          expect_beat(ring_words[slot], STAT_OK, 1'b1);
          if (code == REQ_POP_FRONT) begin
            head_slot = (head_slot + 1) % DEPTH;
            fill_level--;
          end else if (code == REQ_POP_BACK) begin
            fill_level--;
          end
        end
      end
      REQ_DUMP: begin
        if (fill_level == 0) begin
          expect_beat('0, STAT_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < fill_level; i++) begin
            expect_beat(ring_words[(head_slot + i) % DEPTH], STAT_OK, i == fill_level - 1);
          end
        end
      end
      // An unused code is answered with a plain ok beat and changes nothing.
      default: begin
        expect_beat('0, STAT_OK, 1'b1);
      end
    endcase
  endfunction

  task automatic check_beat();
    dq_beat_t want;
    beat_count++;
    if (m_tuser == STAT_FULL) full_count++;
    if (m_tuser == STAT_EMPTY) empty_count++;
    if (expected_beats.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("ERROR @%0t: unexpected beat data %h status %0d last %0b",
                 $realtime, m_tdata, m_tuser, m_tlast);
      end
    end else begin
      want = expected_beats.pop_front();
      if (m_tdata !== want.value || m_tuser !== want.status || m_tlast !== want.last) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("ERROR @%0t: expected data %h status %0d last %0b, got %h %0d %0b",
                   $realtime, want.value, want.status, want.last, m_tdata, m_tuser, m_tlast);
        end
      end
    end
  endtask

  // Results are taken before the request of the same edge, which cannot have produced them yet.
  always @(posedge clk) begin
    if (rst) begin
      head_slot  = 0;
      fill_level = 0;
      expected_beats.delete();
      pending = 0;
    end else begin
      if (m_tvalid && m_tready) check_beat();
      if (s_tvalid && s_tready) predict_request(s_tuser, s_tdata);
      pending = expected_beats.size();
    end
  end

endmodule

// File: dv/tb_double_ended_queue.sv
`timescale 1ns / 1ps
// Testbench top for the double-ended queue: drives requests, applies back-pressure, gives verdict.
module tb_double_ended_queue;
  import dq_pkg::*;

  localparam logic [REQ_W-1:0] REQ_SPARE = 3'd7;
  localparam int REQUEST_TARGET = 310;
  localparam int IDLE_PCT       = 16;
  localparam int HOLD_CYCLES    = 80;
  localparam int STALL_LIMIT    = 2000;
  localparam int SETTLE_CYCLES  = 2 * DEPTH + 8;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [WORD_W-1:0] s_tdata  = '0;
  logic [REQ_W-1:0]  s_tuser  = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [WORD_W-1:0] m_tdata;
  logic [STAT_W-1:0] m_tuser;
  logic              m_tlast;

  int fail_count;
  int pending;
  int beat_count;
  int full_count;
  int empty_count;
  int requests_sent = 0;
  int stall_cycles  = 0;
  bit calm          = 1'b0;
  bit hold_req      = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  double_ended_queue dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  dq_checker chk (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .fail_count  (fail_count),
    .pending     (pending),
    .beat_count  (beat_count),
    .full_count  (full_count),
    .empty_count (empty_count)
  );

  // Ends the run when neither side has moved a beat for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off when the stimulus asks for it.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic send_request(input logic [REQ_W-1:0] code, input logic [WORD_W-1:0] word);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= code;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    requests_sent++;
  endtask

  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Pushes past capacity so the store ends full and rejects the extra words.
  task automatic fill_store();
    for (int i = 0; i < DEPTH + 3; i++) begin
      send_request($urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, $urandom());
    end
  endtask

  // Sends more pops and peeks together than the store holds entries, mostly pops.
  task automatic drain_store();
    int roll;
    for (int i = 0; i < DEPTH + 4; i++) begin
      roll = $urandom_range(99);
      if (roll < 75) begin
        send_request($urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT, $urandom());
      end else begin
        send_request($urandom_range(1) ? REQ_PEEK_BACK : REQ_PEEK_FRONT, $urandom());
      end
    end
  endtask

  task automatic mixed_requests(input int count);
    int roll;
    logic [REQ_W-1:0] code;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < 42) code = $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
      else if (roll < 66) code = $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
      else if (roll < 84) code = $urandom_range(1) ? REQ_PEEK_BACK : REQ_PEEK_FRONT;
      else if (roll < 94) code = REQ_DUMP;
      else code = REQ_SPARE;
      send_request(code, $urandom());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Every read-type request on an empty store, and an unused code.
    send_request(REQ_POP_FRONT, 32'h0000_0000);
    send_request(REQ_POP_BACK, 32'hFFFF_FFFF);
    send_request(REQ_PEEK_FRONT, 32'h5555_5555);
    send_request(REQ_PEEK_BACK, 32'hAAAA_AAAA);
    send_request(REQ_DUMP, 32'h0000_0000);
    send_request(REQ_SPARE, 32'h1234_5678);
    // Extreme words at both ends, then read them back every way.
    send_request(REQ_PUSH_FRONT, 32'h7FFF_FFFF);
    send_request(REQ_PUSH_BACK, 32'h8000_0000);
    send_request(REQ_PUSH_FRONT, 32'hFFFF_FFFF);
    send_request(REQ_PUSH_BACK, 32'h0000_0000);
    send_request(REQ_PEEK_FRONT, 32'h0000_0000);
    send_request(REQ_PEEK_BACK, 32'h0000_0000);
    send_request(REQ_DUMP, 32'hFFFF_FFFF);
    send_request(REQ_POP_BACK, 32'h0000_0000);
    send_request(REQ_POP_FRONT, 32'h0000_0000);
    send_request(REQ_SPARE, 32'hFFFF_FFFF);
    send_request(REQ_DUMP, 32'h0000_0000);
    send_request(REQ_POP_FRONT, 32'h0000_0000);
    send_request(REQ_POP_BACK, 32'h0000_0000);
    send_request(REQ_POP_FRONT, 32'h0000_0000);
    send_request(REQ_DUMP, 32'h0000_0000);

    // Full-rate fill with no idling on either side.
    calm = 1'b1;
    fill_store();
    send_request(REQ_DUMP, 32'h0000_0000);
    calm = 1'b0;

    // Long receiver hold-off while requests keep coming, so the input stalls.
    hold_req = 1'b1;
    mixed_requests(12);
    wait_results_drained();
    drain_store();

    while (requests_sent < REQUEST_TARGET) begin
      case ($urandom_range(9))
        0: fill_store();
        1: drain_store();
        default: mixed_requests(20);
      endcase
    end

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Sent %0d requests over all request codes, with fills past capacity and drains.",
             requests_sent);
    $display("Checked %0d result beats, %0d full and %0d empty reports.",
             beat_count, full_count, empty_count);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
